// ===== hdl/isfd_pkg.sv =====
// ----------------------------------------------------------------------------
// isfd_pkg
// Shared types and constants for the IMU serial frame decoder.
// ----------------------------------------------------------------------------
package isfd_pkg;

  // Queue between framer and scaler
  localparam int unsigned QUEUE_DEPTH = 2;

  // Frame layout
  localparam logic [7:0] HEADER_RESET = 8'h55;
  localparam logic [3:0] LAST_POS     = 4'd10;   // position of the eleventh byte
  localparam logic [3:0] STORE_LAST   = 4'd7;    // last stored position

  // Frame type bytes
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // Result kind codes
  localparam logic [1:0] KIND_ACC   = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // Scale multipliers: acc *49/40, rate *125/128, angle *45/64
  localparam logic [7:0] MUL_ACC   = 8'd49;
  localparam logic [7:0] MUL_RATE  = 8'd125;
  localparam logic [7:0] MUL_ANGLE = 8'd45;

  // acc: floor(p/40) = floor(floor(p/8)/5); bias keeps the dividend positive
  localparam logic [23:0] ACC_BIAS_Q  = 24'd204800;  // 5 * 40960
  localparam logic [17:0] ACC_BIAS_D  = 18'd40960;
  localparam logic [21:0] RECIP_5     = 22'd3355444; // ceil(2^24 / 5)

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  raw_x;
    logic signed [15:0]  raw_y;
    logic signed [15:0]  raw_z;
  } isfd_item_t;

  typedef struct packed {
    logic       push;
    isfd_item_t item;
  } isfd_push_t;

  typedef struct packed {
    logic       valid;
    isfd_item_t item;
  } isfd_head_t;

endpackage

// ===== hdl/isfd_front.sv =====
// ----------------------------------------------------------------------------
// isfd_front
// Byte framer: header match, position count, frame store, type classify.
// ----------------------------------------------------------------------------
module isfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output logic               cfg_ready,
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  output logic               in_ready,
  input  logic               q_ready,
  output isfd_pkg::isfd_push_t push
);
  import isfd_pkg::*;

  logic [7:0] header_r;
  logic [3:0] count_r, count_nxt;
  logic [7:0] store_r [7];
  logic       accept;
  logic       known;
  logic [1:0] kind;
  logic [2:0] wr_idx;

  assign cfg_ready = 1'b1;
  // only the frame-closing byte needs queue space
  assign in_ready  = (count_r != LAST_POS) || q_ready;
  assign accept    = in_valid && in_ready;
  assign wr_idx    = count_r[2:0] - 3'd1;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      priority if (count_r == 4'd0) begin
        count_nxt = (in_rx_byte == header_r) ? 4'd1 : 4'd0;
      end else if (count_r == LAST_POS) begin
        count_nxt = 4'd0;
      end else begin
        count_nxt = count_r + 4'd1;
      end
    end
  end

  always_comb begin
    known = 1'b1;
    kind  = KIND_ACC;
    unique case (store_r[0])
      TYPE_ACC:   kind = KIND_ACC;
      TYPE_RATE:  kind = KIND_RATE;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default:    known = 1'b0;
    endcase
  end

  always_comb begin
    push.push       = accept && (count_r == LAST_POS) && known;
    push.item.kind  = kind;
    push.item.raw_x = {store_r[2], store_r[1]};
    push.item.raw_y = {store_r[4], store_r[3]};
    push.item.raw_z = {store_r[6], store_r[5]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      count_r  <= 4'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        header_r <= cfg_data;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (count_r != 4'd0) && (count_r <= STORE_LAST)) begin
      store_r[wr_idx] <= in_rx_byte;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_POS)
    else $error("byte count out of range");

endmodule

// ===== hdl/isfd_queue.sv =====
// ----------------------------------------------------------------------------
// isfd_queue
// Small FIFO of raw frames between framer and scaler.
// ----------------------------------------------------------------------------
module isfd_queue #(
  parameter int unsigned Depth = isfd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isfd_pkg::isfd_push_t push,
  output logic                 push_ready,
  output isfd_pkg::isfd_head_t head,
  input  logic                 pop
);
  import isfd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  isfd_item_t    mem_r [Depth];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign do_push    = push.push;
  assign do_pop     = pop;
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |-> (count_r != FULL_CNT) || do_pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> (count_r != '0))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

// ===== hdl/isfd_back.sv =====
// ----------------------------------------------------------------------------
// isfd_back
// Scaler pipeline: multiply, divide/shift, bias correct into output register.
// ----------------------------------------------------------------------------
module isfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isfd_pkg::isfd_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic signed [16:0]   out_axis_x,
  output logic signed [16:0]   out_axis_y,
  output logic signed [16:0]   out_axis_z
);
  import isfd_pkg::*;

  // stage 2: shift for rate/angle, divide by 40 for acceleration
  function automatic logic [17:0] scale_mid(input logic [1:0] kind,
                                            input logic signed [23:0] p);
    logic signed [23:0] q;
    logic [23:0]        u;
    logic [40:0]        m;
    logic signed [23:0] sh;
    q  = p >>> 3;
    u  = q + ACC_BIAS_Q;
    m  = 41'(u[18:0]) * 41'(RECIP_5);
    sh = (kind == KIND_RATE) ? (p >>> 7) : (p >>> 6);
    return (kind == KIND_ACC) ? {1'b0, m[40:24]} : sh[17:0];
  endfunction

  // output stage: remove the acceleration bias
  function automatic logic [16:0] scale_out(input logic [1:0] kind,
                                            input logic [17:0] v);
    logic [17:0] d;
    d = v - ACC_BIAS_D;
    return (kind == KIND_ACC) ? d[16:0] : v[16:0];
  endfunction

  logic               s1_v_r, s1_v_nxt;
  logic [1:0]         s1_kind_r;
  logic signed [23:0] s1_p_r [3];
  logic               s2_v_r, s2_v_nxt;
  logic [1:0]         s2_kind_r;
  logic [17:0]        s2_val_r [3];
  logic               out_v_r, out_v_nxt;
  logic               s1_load, s2_load, out_load;
  logic [7:0]         mul;
  logic signed [24:0] prod [3];

  assign out_load = s2_v_r && (!out_v_r || out_ready);
  assign s2_load  = s1_v_r && (!s2_v_r || out_load);
  assign s1_load  = head.valid && (!s1_v_r || s2_load);
  assign pop      = s1_load;
  assign out_valid = out_v_r;

  always_comb begin
    unique case (head.item.kind)
      KIND_ACC:   mul = MUL_ACC;
      KIND_RATE:  mul = MUL_RATE;
      default:    mul = MUL_ANGLE;
    endcase
    prod[0] = head.item.raw_x * $signed({1'b0, mul});
    prod[1] = head.item.raw_y * $signed({1'b0, mul});
    prod[2] = head.item.raw_z * $signed({1'b0, mul});
  end

  always_comb begin
    s1_v_nxt  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_v_r);
    s2_v_nxt  = s2_load ? 1'b1 : (out_load ? 1'b0 : s2_v_r);
    out_v_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind_r <= head.item.kind;
      for (int i = 0; i < 3; i++) begin
        s1_p_r[i] <= prod[i][23:0];
      end
    end
    if (s2_load) begin
      s2_kind_r <= s1_kind_r;
      for (int i = 0; i < 3; i++) begin
        s2_val_r[i] <= scale_mid(s1_kind_r, s1_p_r[i]);
      end
    end
    if (out_load) begin
      out_kind   <= s2_kind_r;
      out_axis_x <= scale_out(s2_kind_r, s2_val_r[0]);
      out_axis_y <= scale_out(s2_kind_r, s2_val_r[1]);
      out_axis_z <= scale_out(s2_kind_r, s2_val_r[2]);
    end
  end

  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_kind == KIND_ACC) || (out_kind == KIND_RATE) ||
                (out_kind == KIND_ANGLE))
    else $error("result with invalid kind");

  a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_v_r && !out_ready) |=> s2_v_r)
    else $error("stage 2 item lost under stall");

endmodule

// ===== hdl/imu_serial_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder_top
// IMU 11-byte serial frame decoder: framer, frame queue, scaler pipeline.
// ----------------------------------------------------------------------------
// Feed one received byte per transfer on the in_ channel; the block takes a
// byte every cycle and only holds in_ready low on the eleventh byte of a
// frame when the frame queue is full. A frame opens with the byte in the
// header register (0x55 after reset; the user rewrites it through the cfg_
// channel only while idle, the block itself does not enforce this); any
// other byte at position zero is dropped. On the eleventh byte, type
// 0x51/0x52/0x53 queues a frame of kind acceleration, angular rate or angle;
// other types are dropped, and the checksum is not checked. A frame is queued
// at the edge that takes its eleventh byte. Out_valid for it rises after the
// queue entry, a multiply stage, a shift / divide-by-five stage and the
// output register. The scaler takes one frame per cycle while its output is
// not stalled, so the sustained rate is one byte per cycle; output stalls
// back up into the QueueDepth-entry queue and from there to the byte input.
// Values are floor-rounded fixed point: acceleration raw*49/40 in 1/256
// m/s^2, rate raw*125/128 in 1/64 deg/s, angle raw*45/64 in 1/128 degree.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top #(
  parameter int unsigned QueueDepth = isfd_pkg::QUEUE_DEPTH  // range 1 and up
) (
  input  logic               clk,
  input  logic               rst_n,
  // header register write
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output logic               cfg_ready,
  // received bytes
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  // decoded results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic signed [16:0] out_axis_x,
  output logic signed [16:0] out_axis_y,
  output logic signed [16:0] out_axis_z
);
  import isfd_pkg::*;

  isfd_push_t push;      // framer -> queue
  isfd_head_t head;      // queue  -> scaler
  logic       q_ready;
  logic       pop;

  // front: header match, byte count, frame store, type classify
  isfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_ready   (in_ready),
    .q_ready    (q_ready),
    .push       (push)
  );

  // decoupling queue of raw frames
  isfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .head       (head),
    .pop        (pop)
  );

  // back: three-stage scaler ending in the output register
  isfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_axis_x (out_axis_x),
    .out_axis_y (out_axis_y),
    .out_axis_z (out_axis_z)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IMU serial frame decoder. A clocked driver
// feeds received bytes from a queue; a clocked monitor tracks framing in a
// local decoder model, queues the decoded result for every completed frame
// of a known type and compares each out_ transfer field by field. The
// header register is rewritten between phases, some of them mid-frame.
// ----------------------------------------------------------------------------
module tb;
  import isfd_pkg::*;

  // Divisors of the three fixed-point scalings
  localparam int ACC_DIV   = 40;
  localparam int RATE_DIV  = 128;
  localparam int ANGLE_DIV = 64;

  localparam int PHASE_BYTES = 300;   // random bytes per header setting
  localparam int DRAIN_CYC   = 16;    // settle time after the last result
  localparam int HOLD_CYC    = 400;   // long receiver hold-off
  localparam int HOLD_AT     = 700;   // bytes taken before the hold-off starts

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } axis_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [7:0]         cfg_data = 8'h00;
  logic               cfg_ready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic signed [16:0] out_axis_x;
  logic signed [16:0] out_axis_y;
  logic signed [16:0] out_axis_z;

  imu_serial_frame_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_axis_x (out_axis_x),
    .out_axis_y (out_axis_y),
    .out_axis_z (out_axis_z)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Bytes waiting to be sent and decoded results waiting to come out
  logic [7:0]   rx_backlog [$];
  axis_result_t decoded_q [$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_taken = 0;
  logic        byte_done = 1'b0;   // last rising edge completed an in_ transfer
  logic        out_hold = 1'b0;    // long receiver hold-off in progress

  // Local copy of the decoder: header register, byte position, stored bytes
  logic [7:0] hdr_reg = HEADER_RESET;
  logic [3:0] frame_pos = 4'd0;
  logic [7:0] frame_bytes [1:7];

  // --------------------------------------------------------------------------
  // Random gap lengths: mostly back to back, some short gaps, a few long
  // ones. Now and then a burst of zero gaps so that full-rate stretches occur.
  // --------------------------------------------------------------------------
  function automatic int pick_gap(inout int burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      burst = $urandom_range(50, 200);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Floor-rounded raw*mul/div, wrapped to the 17-bit result width
  function automatic logic signed [16:0] scale_floor(input logic signed [15:0] raw,
                                                     input int mul, input int div);
    longint p;
    longint q;
    p = longint'(raw) * mul;
    if (p >= 0) q = p / div;
    else q = -((-p + div - 1) / div);
    return q[16:0];
  endfunction

  // One accepted byte through the framer; a finished frame of a known type
  // queues its decoded result.
  task automatic track_frame_byte(input logic [7:0] b);
    axis_result_t r;
    int           mul;
    int           div;
    logic         known;
    mul = 0;
    div = 1;
    known = 1'b1;
    r = '0;
    if (frame_pos == 4'd0) begin
      // wrong header: dropped, position stays at zero
      if (b == hdr_reg) frame_pos = 4'd1;
    end else begin
      if (frame_pos <= STORE_LAST) frame_bytes[frame_pos] = b;
      if (frame_pos != LAST_POS) begin
        frame_pos = frame_pos + 4'd1;
      end else begin
        frame_pos = 4'd0;
        case (frame_bytes[1])
          TYPE_ACC: begin
            r.kind = KIND_ACC;
            mul = MUL_ACC;
            div = ACC_DIV;
          end
          TYPE_RATE: begin
            r.kind = KIND_RATE;
            mul = MUL_RATE;
            div = RATE_DIV;
          end
          TYPE_ANGLE: begin
            r.kind = KIND_ANGLE;
            mul = MUL_ANGLE;
            div = ANGLE_DIV;
          end
          default: known = 1'b0;   // unknown type: frame dropped
        endcase
        if (known) begin
          r.x = scale_floor({frame_bytes[3], frame_bytes[2]}, mul, div);
          r.y = scale_floor({frame_bytes[5], frame_bytes[4]}, mul, div);
          r.z = scale_floor({frame_bytes[7], frame_bytes[6]}, mul, div);
          decoded_q.push_back(r);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: changes at the falling edge. A byte on the bus stays put
  // until the monitor saw its transfer; then a gap or the next byte.
  // --------------------------------------------------------------------------
  int tx_gap = 0;
  int tx_burst = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_done) begin
      // waiting for the transfer, hold valid and data
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (rx_backlog.size() != 0) begin
      in_valid   <= 1'b1;
      in_rx_byte <= rx_backlog.pop_front();
      tx_gap = pick_gap(tx_burst);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus the long hold-off that lets the
  // frame queue fill and pushes back on the byte input.
  // --------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_burst = 0;

  always @(negedge clk) begin
    if (!rst_n || out_hold) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_wait = pick_gap(rx_burst);
    end
  end

  initial begin
    wait (bytes_taken >= HOLD_AT);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    out_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Results are checked
  // first; a result cannot leave in the cycle its frame completes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    axis_result_t e;
    byte_done <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual kind %0d x %0d y %0d z %0d",
                 $time, out_kind, out_axis_x, out_axis_y, out_axis_z);
        mismatch_count++;
      end else begin
        e = decoded_q.pop_front();
        check_field("kind", e.kind, out_kind);
        check_field("axis_x", e.x, out_axis_x);
        check_field("axis_y", e.y, out_axis_y);
        check_field("axis_z", e.z, out_axis_z);
      end
    end
    if (rst_n && cfg_valid && cfg_ready) hdr_reg = cfg_data;
    if (rst_n && in_valid && in_ready) begin
      track_frame_byte(in_rx_byte);
      bytes_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Data words lean toward the corners of the 16-bit range
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1, 2: return TYPE_ACC;
      3, 4, 5: return TYPE_RATE;
      6, 7, 8: return TYPE_ANGLE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Full frame: header, type, three little-endian words, three tail bytes
  task automatic add_frame(input logic [7:0] hdr, input logic [7:0] kind_byte,
                           input logic [15:0] wx, input logic [15:0] wy,
                           input logic [15:0] wz);
    rx_backlog.push_back(hdr);
    rx_backlog.push_back(kind_byte);
    rx_backlog.push_back(wx[7:0]);
    rx_backlog.push_back(wx[15:8]);
    rx_backlog.push_back(wy[7:0]);
    rx_backlog.push_back(wy[15:8]);
    rx_backlog.push_back(wz[7:0]);
    rx_backlog.push_back(wz[15:8]);
    repeat (3) rx_backlog.push_back(8'($urandom));
  endtask

  // Mostly well-formed frames with random content, the rest noise bytes
  // and frames cut short.
  task automatic add_random_stream(input logic [7:0] hdr, input int n);
    int stop;
    int r;
    stop = rx_backlog.size() + n;
    while (rx_backlog.size() < stop) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        add_frame(hdr, pick_type(), pick_word(), pick_word(), pick_word());
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) rx_backlog.push_back(8'($urandom));
      end else begin
        rx_backlog.push_back(hdr);
        repeat ($urandom_range(1, 9)) rx_backlog.push_back(8'($urandom));
      end
    end
  endtask

  // Wait until every byte went in and every result came out, then let the
  // pipeline settle: a dropped frame may still be in flight.
  task automatic wait_idle();
    do @(posedge clk);
    while (rx_backlog.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] phase_hdr [6];
    phase_hdr[0] = 8'h00;
    phase_hdr[1] = 8'hFF;
    phase_hdr[2] = 8'($urandom);
    phase_hdr[3] = HEADER_RESET;
    phase_hdr[4] = 8'($urandom);
    phase_hdr[5] = TYPE_ANGLE;   // header equal to a type byte

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset header: bytes that are not a header,
    // the word extremes on each kind, and a frame of unknown type.
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'hFF);
    add_frame(HEADER_RESET, TYPE_ACC, 16'h8000, 16'h7FFF, 16'hFFFF);
    add_frame(HEADER_RESET, TYPE_RATE, 16'h7FFF, 16'h8000, 16'h0001);
    add_frame(HEADER_RESET, TYPE_ANGLE, 16'hFFFF, 16'h0000, 16'h8000);
    add_frame(HEADER_RESET, 8'h54, 16'h1234, 16'h8000, 16'h7FFF);
    // open a frame that finishes after the next header write
    rx_backlog.push_back(HEADER_RESET);
    rx_backlog.push_back(TYPE_RATE);
    repeat (4) rx_backlog.push_back(8'($urandom));

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_header(phase_hdr[ph]);
      add_random_stream(phase_hdr[ph], PHASE_BYTES);
      if (ph != 5) begin
        // partial frame left open across the next header change
        rx_backlog.push_back(phase_hdr[ph]);
        rx_backlog.push_back(pick_type());
        repeat (4) rx_backlog.push_back(8'($urandom));
      end
    end

    wait_idle();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== imu_serial_frame_decoder_top.f =====
hdl/isfd_pkg.sv
hdl/isfd_front.sv
hdl/isfd_queue.sv
hdl/isfd_back.sv
hdl/imu_serial_frame_decoder_top.sv
dv/tb.sv
